[src/mfde_pkg.sv]
// Shared types and constants of the monochrome frame store draw engine.
package mfde_pkg;

    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 16;
    localparam int OP_W     = 3;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 11;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_GET   = 3'd1;
    localparam logic [OP_W-1:0] OP_VLINE = 3'd2;
    localparam logic [OP_W-1:0] OP_HLINE = 3'd3;
    localparam logic [OP_W-1:0] OP_RECT  = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd5;

    localparam logic [CFG_IW-1:0] REG_LOGICAL_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LOGICAL_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PANEL_WIDTH    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PANEL_HEIGHT   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ROTATION_MODE  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_STORE_BYTES    = 3'd5;

    localparam logic [7:0]  RST_LOGICAL_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_LOGICAL_HEIGHT = 8'd64;
    localparam logic [7:0]  RST_PANEL_WIDTH    = 8'd128;
    localparam logic [6:0]  RST_PANEL_HEIGHT   = 7'd64;
    localparam logic [1:0]  RST_ROTATION_MODE  = 2'd0;
    localparam logic [10:0] RST_STORE_BYTES    = 11'd1024;

    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic accept;
        logic pix_rd;
        logic pix_wb;
        logic sweep;
        logic push;
    } mfde_cmd_t;

    typedef struct packed {
        logic in_rect;
        logic in_fill;
        logic in_empty;
        logic pix_last;
        logic sweep_last;
        logic out_free;
    } mfde_stat_t;

endpackage

[src/mfde_if.sv]
// Request, response and configuration channel interfaces.
interface mfde_req_if;
    logic                              valid;
    logic                              ready;
    logic [mfde_pkg::OP_W-1:0]         opcode;
    logic signed [mfde_pkg::COORD_W-1:0] pos_x;
    logic signed [mfde_pkg::COORD_W-1:0] pos_y;
    logic signed [mfde_pkg::COORD_W-1:0] extent_w;
    logic signed [mfde_pkg::COORD_W-1:0] extent_h;
    logic                              ink;

    modport source (output valid, opcode, pos_x, pos_y, extent_w, extent_h, ink,
                    input ready);
    modport sink (input valid, opcode, pos_x, pos_y, extent_w, extent_h, ink,
                  output ready);
endinterface

interface mfde_rsp_if;
    logic valid;
    logic ready;
    logic pixel_value;

    modport source (output valid, pixel_value, input ready);
    modport sink (input valid, pixel_value, output ready);
endinterface

interface mfde_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mfde_pkg::CFG_IW-1:0] index;
    logic [mfde_pkg::CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/mfde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/mfde_ctrl.sv]
// Sequencer for clearing, per-pixel read-modify-write, screen fill and response.
module mfde_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mfde_pkg::mfde_stat_t stat,
    output mfde_pkg::mfde_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PIX_RD = 3'd2;
    localparam logic [2:0] S_PIX_WB = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_rect && !stat.in_empty)
                    begin
                        state_next = S_PIX_RD;
                    end
                    else if (stat.in_fill && !stat.in_empty)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_PIX_RD:
            begin
                cmd.pix_rd = 1'b1;
                state_next = S_PIX_WB;
            end
            S_PIX_WB:
            begin
                cmd.pix_wb = 1'b1;
                if (!stat.pix_last)
                begin
                    state_next = S_PIX_RD;
                end
                else if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[src/mfde_dpath.sv]
// Clipping, rotation, address generation, frame store and response register.
module mfde_dpath #(
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mfde_pkg::mfde_cmd_t                  cmd,
    output mfde_pkg::mfde_stat_t                 stat,
    input  logic [mfde_pkg::OP_W-1:0]            opcode,
    input  logic signed [mfde_pkg::COORD_W-1:0]  pos_x,
    input  logic signed [mfde_pkg::COORD_W-1:0]  pos_y,
    input  logic signed [mfde_pkg::COORD_W-1:0]  extent_w,
    input  logic signed [mfde_pkg::COORD_W-1:0]  extent_h,
    input  logic                                 ink,
    input  logic                                 cfg_we,
    input  logic [mfde_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [mfde_pkg::CFG_DW-1:0]          cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_pixel
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = mfde_pkg::BYTE_W;

    // configuration
    logic [7:0]  lw_reg;
    logic [7:0]  lh_reg;
    logic [7:0]  pw_reg;
    logic [6:0]  ph_reg;
    logic [1:0]  rot_reg;
    logic [10:0] sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg  <= mfde_pkg::RST_LOGICAL_WIDTH;
            lh_reg  <= mfde_pkg::RST_LOGICAL_HEIGHT;
            pw_reg  <= mfde_pkg::RST_PANEL_WIDTH;
            ph_reg  <= mfde_pkg::RST_PANEL_HEIGHT;
            rot_reg <= mfde_pkg::RST_ROTATION_MODE;
            sb_reg  <= mfde_pkg::RST_STORE_BYTES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfde_pkg::REG_LOGICAL_WIDTH:  lw_reg  <= cfg_data[7:0];
                mfde_pkg::REG_LOGICAL_HEIGHT: lh_reg  <= cfg_data[7:0];
                mfde_pkg::REG_PANEL_WIDTH:    pw_reg  <= cfg_data[7:0];
                mfde_pkg::REG_PANEL_HEIGHT:   ph_reg  <= cfg_data[6:0];
                mfde_pkg::REG_ROTATION_MODE:  rot_reg <= cfg_data[1:0];
                mfde_pkg::REG_STORE_BYTES:    sb_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // request decode and clipping
    logic signed [15:0] w_eff;
    logic signed [15:0] h_eff;
    logic signed [16:0] xs_full;
    logic signed [16:0] ys_full;
    logic signed [16:0] xe_full;
    logic signed [16:0] ye_full;
    logic signed [16:0] xe_clip;
    logic signed [16:0] ye_clip;
    logic signed [16:0] lw_s;
    logic signed [16:0] lh_s;
    logic               rect_empty;
    logic [CW-1:0]      fill_n;

    always_comb
    begin
        case (opcode) inside
            mfde_pkg::OP_SET, mfde_pkg::OP_GET:
            begin
                w_eff = 16'sd1;
                h_eff = 16'sd1;
            end
            mfde_pkg::OP_VLINE:
            begin
                w_eff = 16'sd1;
                h_eff = extent_h;
            end
            mfde_pkg::OP_HLINE:
            begin
                w_eff = extent_w;
                h_eff = 16'sd1;
            end
            default:
            begin
                w_eff = extent_w;
                h_eff = extent_h;
            end
        endcase
    end

    assign lw_s    = $signed({9'b0, lw_reg});
    assign lh_s    = $signed({9'b0, lh_reg});
    assign xs_full = pos_x[15] ? 17'sd0 : $signed({1'b0, pos_x});
    assign ys_full = pos_y[15] ? 17'sd0 : $signed({1'b0, pos_y});
    assign xe_full = $signed({pos_x[15], pos_x}) + $signed({w_eff[15], w_eff});
    assign ye_full = $signed({pos_y[15], pos_y}) + $signed({h_eff[15], h_eff});
    assign xe_clip = (xe_full > lw_s) ? lw_s : xe_full;
    assign ye_clip = (ye_full > lh_s) ? lh_s : ye_full;
    assign rect_empty = !((xs_full < xe_clip) && (ys_full < ye_clip));
    assign fill_n = ({6'b0, sb_reg} < 17'(DEPTH)) ? CW'(sb_reg) : CW'(DEPTH);

    // rectangle walk
    logic [7:0] i_reg;
    logic [7:0] j_reg;
    logic [7:0] ys_reg;
    logic [7:0] xe_reg;
    logic [7:0] ye_reg;
    logic       op_get_reg;
    logic       ink_reg;
    logic       res_reg;
    logic [8:0] i_inc;
    logic [8:0] j_inc;
    logic       j_wrap;

    assign i_inc  = {1'b0, i_reg} + 9'd1;
    assign j_inc  = {1'b0, j_reg} + 9'd1;
    assign j_wrap = (j_inc >= {1'b0, ye_reg});

    // rotation and addressing
    logic signed [9:0] pw_s;
    logic signed [9:0] ph_s;
    logic signed [9:0] i_s;
    logic signed [9:0] j_s;
    logic signed [9:0] px;
    logic signed [9:0] py;
    logic [12:0]       page_off;
    logic [16:0]       a_full;
    logic              loc_hit;
    logic [AW-1:0]     loc_addr;
    logic [AW-1:0]     addr_reg;
    logic [2:0]        bit_reg;
    logic              hit_reg;

    assign pw_s = $signed({2'b0, pw_reg});
    assign ph_s = $signed({3'b0, ph_reg});
    assign i_s  = $signed({2'b0, i_reg});
    assign j_s  = $signed({2'b0, j_reg});

    always_comb
    begin
        case (rot_reg)
            mfde_pkg::ROT_90:
            begin
                px = pw_s - j_s - 10'sd1;
                py = i_s;
            end
            mfde_pkg::ROT_180:
            begin
                px = pw_s - i_s - 10'sd1;
                py = ph_s - j_s - 10'sd1;
            end
            mfde_pkg::ROT_270:
            begin
                px = j_s;
                py = ph_s - i_s - 10'sd1;
            end
            default:
            begin
                px = i_s;
                py = j_s;
            end
        endcase
    end

    assign page_off = {8'b0, py[7:3]} * {5'b0, pw_reg};
    assign a_full   = {8'b0, px[8:0]} + {4'b0, page_off};
    assign loc_hit  = !px[9] && !py[9] && (a_full < 17'(DEPTH));
    assign loc_addr = a_full[AW-1:0];

    // fill sweep
    logic [CW-1:0] k_reg;
    logic [CW-1:0] sweep_end_reg;
    logic          fill_ink_reg;
    logic [CW-1:0] k_inc;

    assign k_inc = k_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            sweep_end_reg <= CW'(DEPTH);
            fill_ink_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            k_reg         <= '0;
            sweep_end_reg <= fill_n;
            fill_ink_reg  <= ink;
        end
        else if (cmd.sweep)
        begin
            k_reg <= k_inc;
        end
    end

    // frame store
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [BW-1:0] ram_rdata;
    logic [BW-1:0] bit_mask;

    assign bit_mask  = BW'(1) << bit_reg;
    assign ram_we    = cmd.sweep || (cmd.pix_wb && hit_reg && !op_get_reg);
    assign ram_waddr = cmd.sweep ? k_reg[AW-1:0] : addr_reg;
    assign ram_wdata = cmd.sweep ? {BW{fill_ink_reg}}
                     : (ink_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask));

    mfde_ram #(
        .WIDTH (BW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (loc_addr),
        .rdata (ram_rdata)
    );

    logic rd_bit;
    logic res_now;

    assign rd_bit  = hit_reg && ram_rdata[bit_reg];
    assign res_now = (cmd.pix_wb && op_get_reg) ? rd_bit : res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            i_reg      <= xs_full[7:0];
            j_reg      <= ys_full[7:0];
            ys_reg     <= ys_full[7:0];
            xe_reg     <= xe_clip[7:0];
            ye_reg     <= ye_clip[7:0];
            op_get_reg <= (opcode == mfde_pkg::OP_GET);
            ink_reg    <= ink;
            res_reg    <= 1'b0;
        end
        else if (cmd.pix_wb)
        begin
            if (op_get_reg)
            begin
                res_reg <= rd_bit;
            end
            if (j_wrap)
            begin
                j_reg <= ys_reg;
                i_reg <= i_inc[7:0];
            end
            else
            begin
                j_reg <= j_inc[7:0];
            end
        end
        if (cmd.pix_rd)
        begin
            addr_reg <= loc_addr;
            bit_reg  <= py[2:0];
            hit_reg  <= loc_hit;
        end
    end

    // response register
    logic out_valid_reg;
    logic out_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_pix_reg <= res_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pix_reg;

    assign stat.in_rect    = (opcode <= mfde_pkg::OP_RECT);
    assign stat.in_fill    = (opcode == mfde_pkg::OP_FILL);
    assign stat.in_empty   = (opcode == mfde_pkg::OP_FILL) ? (fill_n == '0) : rect_empty;
    assign stat.pix_last   = j_wrap && (i_inc >= {1'b0, xe_reg});
    assign stat.sweep_last = (k_inc == sweep_end_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

[src/mono_framebuffer_draw_engine_unit.sv]
// Top level of the monochrome page-organized frame store draw engine.
//
// Channels: req carries one drawing request (opcode, pos_x, pos_y, extent_w,
// extent_h, ink); rsp returns one pixel_value per request, 1 only for a get
// that hits a set pixel. cfg writes one of six registers (index 0 to 5) and
// is always ready; write it only while no request is in flight.
// Timing: one request at a time. Each clipped pixel of a set, get, line or
// rectangle passes through a read state and a write-back state, a read-modify-
// write through the frame store RAM with its registered read port (a get
// writes nothing back); a whole screen fill writes min(store_bytes, depth)
// bytes, one byte per cycle, and anything clipped away or an unknown opcode
// goes straight to the response.
// Reset: rst_n resets the control and configuration registers and starts a
// clearing pass over the MAX_PANEL_WIDTH * MAX_PANEL_HEIGHT / 8 bytes of the
// frame store (1024 by default), during which req.ready stays low.
// Stall: the response sits in an output register; a new request is taken
// while it waits, and that request's response holds in the engine until
// the register frees.
module mono_framebuffer_draw_engine_unit #(
    parameter int MAX_PANEL_WIDTH  = 128,
    parameter int MAX_PANEL_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    mfde_req_if.sink   req,
    mfde_rsp_if.source rsp,
    mfde_cfg_if.sink   cfg
);

    localparam int DEPTH = MAX_PANEL_WIDTH * MAX_PANEL_HEIGHT / 8;

    mfde_pkg::mfde_cmd_t  cmd;
    mfde_pkg::mfde_stat_t stat;

    assign cfg.ready = 1'b1;

    mfde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mfde_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (req.opcode),
        .pos_x     (req.pos_x),
        .pos_y     (req.pos_y),
        .extent_w  (req.extent_w),
        .extent_h  (req.extent_h),
        .ink       (req.ink),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_pixel (rsp.pixel_value)
    );

endmodule

[src/mfde_checker.sv]
// Port-level assertions for the draw engine and their bind.
module mfde_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_pixel_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value))
        else $error("response dropped or changed while stalled");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !req_ready)
        else $error("request ready before frame store clear");

    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared while engine was idle");

endmodule

bind mono_framebuffer_draw_engine_unit mfde_checker u_mfde_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_pixel_value (rsp.pixel_value)
);

[tb/sv/mono_framebuffer_draw_engine_unit_tb.sv]
// Self-checking testbench of the frame store draw engine: directed table, then random requests.
`timescale 1ns / 100ps

module mono_framebuffer_draw_engine_unit_tb;

    localparam int STORE_DEPTH      = 1024;
    localparam int WATCHDOG_LIMIT   = 150000;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DIRECTED_COUNT   = 27;
    localparam int MAX_REPORTS      = 40;

    localparam logic [mfde_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [mfde_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic signed [mfde_pkg::COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [mfde_pkg::COORD_W-1:0] COORD_MAX = 16'sh7FFF;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [mfde_pkg::OP_W-1:0]           opcode;
        logic signed [mfde_pkg::COORD_W-1:0] pos_x;
        logic signed [mfde_pkg::COORD_W-1:0] pos_y;
        logic signed [mfde_pkg::COORD_W-1:0] extent_w;
        logic signed [mfde_pkg::COORD_W-1:0] extent_h;
        logic                                ink;
    } draw_req_t;

    typedef struct packed {
        draw_req_t cmd;
        logic      typed;
        logic      typed_pixel;
    } table_row_t;

    table_row_t directed_rows [DIRECTED_COUNT] = '{
        '{'{mfde_pkg::OP_GET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd127, 16'sd63, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_SET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b1},
        '{'{mfde_pkg::OP_SET, 16'sd127, 16'sd63, 16'sd0, 16'sd0, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd127, 16'sd63, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b1},
        '{'{mfde_pkg::OP_GET, COORD_MIN, COORD_MIN, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_GET, COORD_MAX, COORD_MAX, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_SET, 16'sd128, 16'sd0, 16'sd0, 16'sd0, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd128, 16'sd0, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_VLINE, 16'sd5, 16'sd60, 16'sd0, COORD_MAX, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd5, 16'sd63, 16'sd0, 16'sd0, 1'b0}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_HLINE, COORD_MIN, 16'sd10, COORD_MAX, 16'sd0, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_HLINE, 16'sd100, 16'sd10, COORD_MAX, 16'sd0, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd127, 16'sd10, 16'sd0, 16'sd0, 1'b0}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_RECT, 16'sd10, 16'sd10, COORD_MIN, 16'sd5, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd10, 16'sd10, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_RECT, 16'sd20, 16'sd20, 16'sd3, 16'sd3, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd22, 16'sd22, 16'sd0, 16'sd0, 1'b0}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_SET, 16'sd21, 16'sd21, 16'sd0, 16'sd0, 1'b0}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd21, 16'sd21, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0},
        '{'{OP_RSVD6, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, TYPED, 1'b0},
        '{'{OP_RSVD7, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1}, TYPED, 1'b0},
        '{'{mfde_pkg::OP_FILL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd64, 16'sd32, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b1},
        '{'{mfde_pkg::OP_RECT, 16'sd0, 16'sd0, COORD_MAX, COORD_MAX, 1'b0}, PREDICTED, 1'b0},
        '{'{mfde_pkg::OP_GET, 16'sd64, 16'sd32, 16'sd0, 16'sd0, 1'b0}, TYPED, 1'b0}
    };

    logic clk;
    logic rst_n;

    mfde_req_if req_bus ();
    mfde_rsp_if rsp_bus ();
    mfde_cfg_if cfg_bus ();

    mono_framebuffer_draw_engine_unit #(
        .MAX_PANEL_WIDTH  (128),
        .MAX_PANEL_HEIGHT (64)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    logic [7:0]  frame_copy [STORE_DEPTH];
    logic [7:0]  view_w;
    logic [7:0]  view_h;
    logic [7:0]  panel_w;
    logic [6:0]  panel_h;
    logic [1:0]  rot_sel;
    logic [10:0] fill_len;

    logic expected_pixels [$];

    logic signed [mfde_pkg::COORD_W-1:0] last_x = '0;
    logic signed [mfde_pkg::COORD_W-1:0] last_y = '0;

    bit steady_flow    = 1'b0;
    bit hold_off_armed = 1'b0;
    bit hold_off_done  = 1'b0;

    int request_count  = 0;
    int response_count = 0;
    int setting_count  = 0;
    int ones_read      = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic bit in_view(int x, int y);
        return x >= 0 && y >= 0 && x < int'(view_w) && y < int'(view_h);
    endfunction

    function automatic bit map_point(int x, int y, output int addr, output int bitpos);
        int px;
        int py;
        int pw;
        int ph;
        pw = int'(panel_w);
        ph = int'(panel_h);
        px = x;
        py = y;
        case (rot_sel)
            mfde_pkg::ROT_90:
            begin
                px = pw - y - 1;
                py = x;
            end
            mfde_pkg::ROT_180:
            begin
                px = pw - x - 1;
                py = ph - y - 1;
            end
            mfde_pkg::ROT_270:
            begin
                px = y;
                py = ph - x - 1;
            end
            default: ;
        endcase
        addr = 0;
        bitpos = 0;
        if (px < 0 || py < 0)
            return 1'b0;
        addr = px + (py / 8) * pw;
        if (addr >= STORE_DEPTH)
            return 1'b0;
        bitpos = py % 8;
        return 1'b1;
    endfunction

    function automatic void plot_pixel(int x, int y, logic on);
        int addr;
        int bitpos;
        if (in_view(x, y) && map_point(x, y, addr, bitpos))
            frame_copy[addr][bitpos] = on;
    endfunction

    function automatic logic peek_pixel(int x, int y);
        int addr;
        int bitpos;
        if (in_view(x, y) && map_point(x, y, addr, bitpos))
            return frame_copy[addr][bitpos];
        return 1'b0;
    endfunction

    function automatic void fill_span(int x0, int y0, int w, int h, logic on);
        int xs;
        int ys;
        int xe;
        int ye;
        xs = x0 < 0 ? 0 : x0;
        ys = y0 < 0 ? 0 : y0;
        xe = x0 + w;
        ye = y0 + h;
        if (xe > int'(view_w))
            xe = int'(view_w);
        if (ye > int'(view_h))
            ye = int'(view_h);
        for (int i = xs; i < xe; i++)
            for (int j = ys; j < ye; j++)
                plot_pixel(i, j, on);
    endfunction

    function automatic logic apply_request(draw_req_t r);
        int x;
        int y;
        int w;
        int h;
        int n;
        logic pixel;
        x = int'($signed(r.pos_x));
        y = int'($signed(r.pos_y));
        w = int'($signed(r.extent_w));
        h = int'($signed(r.extent_h));
        pixel = 1'b0;
        case (r.opcode)
            mfde_pkg::OP_SET:   plot_pixel(x, y, r.ink);
            mfde_pkg::OP_GET:   pixel = peek_pixel(x, y);
            mfde_pkg::OP_VLINE: fill_span(x, y, 1, h, r.ink);
            mfde_pkg::OP_HLINE: fill_span(x, y, w, 1, r.ink);
            mfde_pkg::OP_RECT:  fill_span(x, y, w, h, r.ink);
            mfde_pkg::OP_FILL:
            begin
                n = int'(fill_len) < STORE_DEPTH ? int'(fill_len) : STORE_DEPTH;
                for (int k = 0; k < n; k++)
                    frame_copy[k] = r.ink ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return pixel;
    endfunction

    // ---------------- random stimulus ----------------

    function automatic logic signed [mfde_pkg::COORD_W-1:0] pick_coord(int span);
        int v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            v = int'($urandom_range(0, span + 7)) - 4;
        else if (r < 90)
            v = $urandom();
        else
        begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = -1;
                default: v = span;
            endcase
        end
        return v[mfde_pkg::COORD_W-1:0];
    endfunction

    function automatic logic signed [mfde_pkg::COORD_W-1:0] pick_extent(int small_max,
                                                                        int wide_pct);
        int v;
        if ($urandom_range(0, 99) < wide_pct)
            v = $urandom();
        else
            v = int'($urandom_range(0, small_max + 2)) - 2;
        return v[mfde_pkg::COORD_W-1:0];
    endfunction

    function automatic draw_req_t random_request();
        draw_req_t r;
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        r.ink = 1'($urandom_range(0, 1));
        r.pos_x = pick_coord(int'(view_w));
        r.pos_y = pick_coord(int'(view_h));
        r.extent_w = pick_extent(12, 10);
        r.extent_h = pick_extent(12, 10);
        if (pick < 30)
            r.opcode = mfde_pkg::OP_SET;
        else if (pick < 55)
        begin
            r.opcode = mfde_pkg::OP_GET;
            // aim half the reads at the latest drawing
            if ($urandom_range(0, 1) == 1)
            begin
                v = int'($signed(last_x)) + int'($urandom_range(0, 3));
                r.pos_x = v[mfde_pkg::COORD_W-1:0];
                v = int'($signed(last_y)) + int'($urandom_range(0, 3));
                r.pos_y = v[mfde_pkg::COORD_W-1:0];
            end
        end
        else if (pick < 65)
        begin
            r.opcode = mfde_pkg::OP_VLINE;
            r.extent_h = pick_extent(40, 15);
        end
        else if (pick < 75)
        begin
            r.opcode = mfde_pkg::OP_HLINE;
            r.extent_w = pick_extent(40, 15);
        end
        else if (pick < 89)
            r.opcode = mfde_pkg::OP_RECT;
        else if (pick < 93)
            r.opcode = mfde_pkg::OP_FILL;
        else
            r.opcode = ($urandom_range(0, 1) == 1) ? OP_RSVD6 : OP_RSVD7;
        if (r.opcode != mfde_pkg::OP_GET && r.opcode != mfde_pkg::OP_FILL)
        begin
            last_x = r.pos_x;
            last_y = r.pos_y;
        end
        return r;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_request(input draw_req_t r, input logic typed, input logic typed_pixel);
        logic due_pixel;
        if (!steady_flow && $urandom_range(0, 99) < 15)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.opcode   <= r.opcode;
        req_bus.pos_x    <= r.pos_x;
        req_bus.pos_y    <= r.pos_y;
        req_bus.extent_w <= r.extent_w;
        req_bus.extent_h <= r.extent_h;
        req_bus.ink      <= r.ink;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        due_pixel = apply_request(r);
        expected_pixels.push_back(typed ? typed_pixel : due_pixel);
        request_count++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(random_request(), PREDICTED, 1'b0);
    endtask

    task automatic settle_engine();
        req_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [mfde_pkg::CFG_IW-1:0] index,
                                  input logic [mfde_pkg::CFG_DW-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (index)
            mfde_pkg::REG_LOGICAL_WIDTH:  view_w   = data[7:0];
            mfde_pkg::REG_LOGICAL_HEIGHT: view_h   = data[7:0];
            mfde_pkg::REG_PANEL_WIDTH:    panel_w  = data[7:0];
            mfde_pkg::REG_PANEL_HEIGHT:   panel_h  = data[6:0];
            mfde_pkg::REG_ROTATION_MODE:  rot_sel  = data[1:0];
            mfde_pkg::REG_STORE_BYTES:    fill_len = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int lw, input int lh, input int pw, input int ph,
                                 input int rot, input int sb);
        settle_engine();
        write_register(mfde_pkg::REG_LOGICAL_WIDTH,  lw[mfde_pkg::CFG_DW-1:0]);
        write_register(mfde_pkg::REG_LOGICAL_HEIGHT, lh[mfde_pkg::CFG_DW-1:0]);
        write_register(mfde_pkg::REG_PANEL_WIDTH,    pw[mfde_pkg::CFG_DW-1:0]);
        write_register(mfde_pkg::REG_PANEL_HEIGHT,   ph[mfde_pkg::CFG_DW-1:0]);
        write_register(mfde_pkg::REG_ROTATION_MODE,  rot[mfde_pkg::CFG_DW-1:0]);
        write_register(mfde_pkg::REG_STORE_BYTES,    sb[mfde_pkg::CFG_DW-1:0]);
        cfg_bus.valid <= 1'b0;
        setting_count++;
    endtask

    // ---------------- response side ----------------

    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_armed && !hold_off_done)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
                rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge clk)
    begin : check_response
        logic want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            response_count++;
            if (rsp_bus.pixel_value === 1'b1)
                ones_read++;
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with no request, expected none, got pixel_value %b",
                             $time, rsp_bus.pixel_value);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (rsp_bus.pixel_value !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: pixel_value mismatch, expected %b, got %b",
                                 $time, want, rsp_bus.pixel_value);
                end
            end
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                 $time, WATCHDOG_LIMIT, expected_pixels.size());
        $display("FAILURE");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.opcode   <= mfde_pkg::OP_SET;
        req_bus.pos_x    <= '0;
        req_bus.pos_y    <= '0;
        req_bus.extent_w <= '0;
        req_bus.extent_h <= '0;
        req_bus.ink      <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= mfde_pkg::REG_LOGICAL_WIDTH;
        cfg_bus.data     <= '0;
        view_w   = mfde_pkg::RST_LOGICAL_WIDTH;
        view_h   = mfde_pkg::RST_LOGICAL_HEIGHT;
        panel_w  = mfde_pkg::RST_PANEL_WIDTH;
        panel_h  = mfde_pkg::RST_PANEL_HEIGHT;
        rot_sel  = mfde_pkg::RST_ROTATION_MODE;
        fill_len = mfde_pkg::RST_STORE_BYTES;
        for (int k = 0; k < STORE_DEPTH; k++)
            frame_copy[k] = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(directed_rows[i].cmd, directed_rows[i].typed,
                         directed_rows[i].typed_pixel);

        run_random(60);
        steady_flow = 1'b1;
        run_random(60);
        steady_flow = 1'b0;
        // receiver stalls while requests keep coming
        hold_off_armed = 1'b1;
        run_random(40);

        apply_setting(128, 128, 128, 64, mfde_pkg::ROT_90, 1024);
        run_random(90);
        apply_setting(64, 32, 64, 32, mfde_pkg::ROT_180, 256);
        run_random(80);
        apply_setting(128, 128, 16, 8, mfde_pkg::ROT_270, 2047);
        run_random(80);
        apply_setting(1, 1, 1, 8, 0, 0);
        run_random(40);
        apply_setting(0, 0, 128, 64, 0, 1024);
        run_random(25);
        repeat (3)
        begin
            apply_setting($urandom_range(1, 128), $urandom_range(1, 128),
                          $urandom_range(1, 128), 8 * $urandom_range(1, 8),
                          $urandom_range(0, 3), $urandom_range(0, 1024));
            run_random(80);
        end
        apply_setting(128, 128, 128, 64, 0, 1024);
        run_random(10);

        settle_engine();
        $display("Sent %0d requests (%0d from the table) over %0d register settings,",
                 request_count, DIRECTED_COUNT, setting_count);
        $display("all rotations, clipping and off-store cases; %0d responses, %0d set pixels read.",
                 response_count, ones_read);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
